// ===== rtl/irbe_pkg.sv =====
// Shared types and constants for the IR ring bearing estimator.
// Used by every module under rtl; depends on nothing else.
package irbe_pkg;

  // sensor ring and sample format
  localparam int SAMPLE_BITS = 10;
  localparam int NUM_SENSORS = 12;
  localparam int COEF_BITS   = 16;

  // Q1.14 cosine and sine of the sensor angles
  localparam int COS_Q14 [NUM_SENSORS] = '{
    16384, 14189, 8192, 0, -8192, -14189,
    -16384, -14189, -8192, 0, 8192, 14189
  };
  localparam int SIN_Q14 [NUM_SENSORS] = '{
    0, 8192, 14189, 16384, 14189, 8192,
    0, -8192, -14189, -16384, -14189, -8192
  };

  // weighted sum widths
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS + 1;
  localparam int GROUP_SIZE  = 4;
  localparam int NUM_GROUPS  = NUM_SENSORS / GROUP_SIZE;
  localparam int SUM_BITS    = PROD_BITS + 4;
  localparam int TOTAL_BITS  = SAMPLE_BITS + 4;
  localparam int FRAC_BITS   = 14;
  localparam int XY_BITS     = SUM_BITS - FRAC_BITS;

  // presence threshold register
  localparam int THRESH_BITS  = 14;
  localparam int THRESH_RESET = 1000;
  localparam int CMP_BITS     = (TOTAL_BITS > THRESH_BITS) ? TOTAL_BITS : THRESH_BITS;

  // cordic datapath, angle in 1/4096 degree
  localparam int CORDIC_SCALE = 16;
  localparam int CRD_BITS     = SAMPLE_BITS + 22;
  localparam int ANG_BITS     = 24;
  localparam int ATAN_LEN     = 24;
  localparam int HALF_TURN_Z  = 737280;
  localparam int ATAN_TAB [ATAN_LEN] = '{
    184320, 108810, 57492, 29184, 14649, 7331, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  // final angle in 1/16 degree
  localparam int ROUND_SHIFT  = 8;
  localparam int ROUND_HALF   = 128;
  localparam int RAW_ANG_BITS = ANG_BITS - ROUND_SHIFT;
  localparam int ANG_OUT_BITS = 13;
  localparam int ANG_LIMIT    = 2880;
  localparam int REAR_EDGE    = 2640;
  localparam int BIN_WIDTH    = 480;
  localparam int NUM_BINS     = 11;
  localparam int SECTOR_BASE  = 7;
  localparam int REAR_BIT     = 6;
  localparam int BEARING_BITS = 13;
  localparam int FULL_TURN    = 5760;
  localparam int MASK_BITS    = 12;

  // one scan of the ring
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;
    logic [SAMPLE_BITS-1:0] sample_8;
    logic [SAMPLE_BITS-1:0] sample_9;
    logic [SAMPLE_BITS-1:0] sample_10;
    logic [SAMPLE_BITS-1:0] sample_11;
  } scan_t;

  // one bearing report
  typedef struct packed {
    logic                    detected;
    logic [BEARING_BITS-1:0] bearing;
    logic [MASK_BITS-1:0]    sector_mask;
  } report_t;

  // per-sensor lane result
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]      inv;
    logic signed [PROD_BITS-1:0] xp;
    logic signed [PROD_BITS-1:0] yp;
  } lane_t;

  // cordic vector state travelling down the pipe
  typedef struct packed {
    logic                       det;
    logic                       zero;
    logic signed [CRD_BITS-1:0] x;
    logic signed [CRD_BITS-1:0] y;
    logic signed [ANG_BITS-1:0] z;
  } crd_state_t;

endpackage

// ===== rtl/ir_ring_bearing_estimator.sv =====
// Top level of the IR ring bearing estimator: lanes, merge, cordic pipe, finish.
// Depends on irbe_pkg, irbe_lane, irbe_merge, irbe_cordic_stage and irbe_finish.
//
// Takes one scan of twelve ring sensors per clock while not halted and returns one
// report per scan, in order, after one lane stage, four merge stages (group sums,
// full sums with the presence check, truncation, half plane fold), one stage per
// cordic iteration and two finish stages. The pipe moves as a whole; it halts only
// while a report sits in the output register and out_stall is high, so in_stall
// simply mirrors that condition. presence_threshold resets to 1000 and is written
// through cfg_valid/cfg_data, always ready; write it only while no scan is in
// flight.
module ir_ring_bearing_estimator
  import irbe_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  scan_t                  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output report_t                out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [THRESH_BITS-1:0] cfg_data
);

  localparam int LATENCY = CORDIC_STEPS + 7;

  logic                   en;
  logic [LATENCY-1:0]     vld;
  logic [THRESH_BITS-1:0] thresh;
  logic [SAMPLE_BITS-1:0] samples [NUM_SENSORS];
  lane_t                  lanes [NUM_SENSORS];
  crd_state_t             chain [CORDIC_STEPS+1];

  // pipeline advance
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LATENCY-1];
  assign cfg_ready = 1'b1;

  // word valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_BITS'(THRESH_RESET);
    end else if (cfg_valid) begin
      thresh <= cfg_data;
    end
  end

  // scan fields to lane inputs
  assign samples[0]  = in_data.sample_0;
  assign samples[1]  = in_data.sample_1;
  assign samples[2]  = in_data.sample_2;
  assign samples[3]  = in_data.sample_3;
  assign samples[4]  = in_data.sample_4;
  assign samples[5]  = in_data.sample_5;
  assign samples[6]  = in_data.sample_6;
  assign samples[7]  = in_data.sample_7;
  assign samples[8]  = in_data.sample_8;
  assign samples[9]  = in_data.sample_9;
  assign samples[10] = in_data.sample_10;
  assign samples[11] = in_data.sample_11;

  // sensor lanes
  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    irbe_lane #(.LANE(i)) u_lane (
      .clk    (clk),
      .en     (en),
      .sample (samples[i]),
      .result (lanes[i])
    );
  end

  // merge lanes into the start vector
  irbe_merge u_merge (
    .clk    (clk),
    .en     (en),
    .thresh (thresh),
    .lanes  (lanes),
    .start  (chain[0])
  );

  // cordic iterations
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    irbe_cordic_stage #(.IDX(s)) u_stage (
      .clk  (clk),
      .en   (en),
      .din  (chain[s]),
      .dout (chain[s+1])
    );
  end

  // angle, bearing and sector
  irbe_finish u_finish (
    .clk  (clk),
    .en   (en),
    .din  (chain[CORDIC_STEPS]),
    .dout (out_data)
  );

endmodule

// ===== rtl/irbe_lane.sv =====
// One sensor lane: inverts a reading and weights it by the sensor's cosine and sine.
// Depends on irbe_pkg.
module irbe_lane
  import irbe_pkg::*;
#(
  parameter int LANE = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] sample,
  output lane_t                  result
);

  localparam logic signed [PROD_BITS-1:0] CX = PROD_BITS'(COS_Q14[LANE]);
  localparam logic signed [PROD_BITS-1:0] CY = PROD_BITS'(SIN_Q14[LANE]);

  logic [SAMPLE_BITS-1:0]      inv;
  logic signed [PROD_BITS-1:0] ve;

  // inverted reading, all ones minus raw
  assign inv = ~sample;
  assign ve  = PROD_BITS'({1'b0, inv});

  // weighted terms
  always_ff @(posedge clk) begin
    if (en) begin
      result.inv <= inv;
      result.xp  <= ve * CX;
      result.yp  <= ve * CY;
    end
  end

endmodule

// ===== rtl/irbe_merge.sv =====
// Merging stage: adds the lane results, checks presence, truncates the sums and
// folds the vector into the right half plane for the cordic. Depends on irbe_pkg.
module irbe_merge
  import irbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [THRESH_BITS-1:0] thresh,
  input  lane_t                  lanes [NUM_SENSORS],
  output crd_state_t             start
);

  localparam logic signed [SUM_BITS-1:0] TRUNC_BIAS = SUM_BITS'((1 << FRAC_BITS) - 1);
  localparam logic signed [ANG_BITS-1:0] Z_POS      = ANG_BITS'(HALF_TURN_Z);
  localparam logic signed [ANG_BITS-1:0] Z_NEG      = ANG_BITS'(-HALF_TURN_Z);

  logic signed [SUM_BITS-1:0]   xa [NUM_GROUPS];
  logic signed [SUM_BITS-1:0]   ya [NUM_GROUPS];
  logic [TOTAL_BITS-1:0]        ta [NUM_GROUPS];
  logic signed [SUM_BITS-1:0]   xa_next [NUM_GROUPS];
  logic signed [SUM_BITS-1:0]   ya_next [NUM_GROUPS];
  logic [TOTAL_BITS-1:0]        ta_next [NUM_GROUPS];
  logic signed [SUM_BITS-1:0]   xs;
  logic signed [SUM_BITS-1:0]   ys;
  logic                         det_b;
  logic [TOTAL_BITS-1:0]        total;
  logic signed [SUM_BITS-1:0]   xb;
  logic signed [SUM_BITS-1:0]   yb;
  logic signed [XY_BITS-1:0]    xt;
  logic signed [XY_BITS-1:0]    yt;
  logic                         det_c;
  logic signed [XY_BITS-1:0]    xr;
  logic signed [XY_BITS-1:0]    yr;
  logic signed [ANG_BITS-1:0]   zr;

  // group partial sums
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      xa_next[g] = '0;
      ya_next[g] = '0;
      ta_next[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        xa_next[g] = xa_next[g] + SUM_BITS'(lanes[g*GROUP_SIZE+j].xp);
        ya_next[g] = ya_next[g] + SUM_BITS'(lanes[g*GROUP_SIZE+j].yp);
        ta_next[g] = ta_next[g] + TOTAL_BITS'(lanes[g*GROUP_SIZE+j].inv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa <= xa_next;
      ya <= ya_next;
      ta <= ta_next;
    end
  end

  // full sums and presence check
  assign total = ta[0] + ta[1] + ta[2];

  always_ff @(posedge clk) begin
    if (en) begin
      xs    <= xa[0] + xa[1] + xa[2];
      ys    <= ya[0] + ya[1] + ya[2];
      det_b <= CMP_BITS'(total) > CMP_BITS'(thresh);
    end
  end

  // truncate toward zero by the coefficient scale
  assign xb = xs + (xs[SUM_BITS-1] ? TRUNC_BIAS : '0);
  assign yb = ys + (ys[SUM_BITS-1] ? TRUNC_BIAS : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      xt    <= xb[SUM_BITS-1:FRAC_BITS];
      yt    <= yb[SUM_BITS-1:FRAC_BITS];
      det_c <= det_b;
    end
  end

  // left half plane turns by half a revolution
  always_comb begin
    if (xt[XY_BITS-1]) begin
      xr = -xt;
      yr = -yt;
      zr = yt[XY_BITS-1] ? Z_NEG : Z_POS;
    end else begin
      xr = xt;
      yr = yt;
      zr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start.det  <= det_c;
      start.zero <= (xt == '0) && (yt == '0);
      start.x    <= {xr[CRD_BITS-CORDIC_SCALE-1:0], {CORDIC_SCALE{1'b0}}};
      start.y    <= {yr[CRD_BITS-CORDIC_SCALE-1:0], {CORDIC_SCALE{1'b0}}};
      start.z    <= zr;
    end
  end

endmodule

// ===== rtl/irbe_cordic_stage.sv =====
// One vectoring cordic iteration with a fixed shift, registered.
// Depends on irbe_pkg.
module irbe_cordic_stage
  import irbe_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       en,
  input  crd_state_t din,
  output crd_state_t dout
);

  localparam logic signed [ANG_BITS-1:0] ANG = ANG_BITS'(ATAN_TAB[IDX]);

  logic signed [CRD_BITS-1:0] xv;
  logic signed [CRD_BITS-1:0] yv;
  logic signed [ANG_BITS-1:0] zv;
  logic signed [CRD_BITS-1:0] dx;
  logic signed [CRD_BITS-1:0] dy;
  logic                       up;

  assign xv = din.x;
  assign yv = din.y;
  assign zv = din.z;
  assign dx = yv >>> IDX;
  assign dy = xv >>> IDX;
  assign up = !yv[CRD_BITS-1] && (yv != '0);

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      dout.det  <= din.det;
      dout.zero <= din.zero;
      if (up) begin
        dout.x <= xv + dx;
        dout.y <= yv - dy;
        dout.z <= zv + ANG;
      end else begin
        dout.x <= xv - dx;
        dout.y <= yv + dy;
        dout.z <= zv - ANG;
      end
    end
  end

endmodule

// ===== rtl/irbe_finish.sv =====
// Final stages: rounds and clamps the angle, then forms bearing and sector mask.
// Depends on irbe_pkg.
module irbe_finish
  import irbe_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  crd_state_t din,
  output report_t    dout
);

  localparam logic signed [ANG_BITS-1:0]     Z_HALF  = ANG_BITS'(ROUND_HALF);
  localparam logic signed [RAW_ANG_BITS-1:0] RAW_MAX = RAW_ANG_BITS'(ANG_LIMIT);
  localparam logic signed [RAW_ANG_BITS-1:0] RAW_MIN = RAW_ANG_BITS'(-ANG_LIMIT);
  localparam logic signed [ANG_OUT_BITS-1:0] REAR_HI = ANG_OUT_BITS'(REAR_EDGE);
  localparam logic signed [ANG_OUT_BITS-1:0] REAR_LO = ANG_OUT_BITS'(-REAR_EDGE);

  logic signed [ANG_BITS-1:0]     zh;
  logic signed [RAW_ANG_BITS-1:0] raw;
  logic signed [ANG_OUT_BITS-1:0] ang_next;
  logic signed [ANG_OUT_BITS-1:0] ang;
  logic                           det;
  logic signed [ANG_OUT_BITS-1:0] lo;
  logic signed [ANG_OUT_BITS-1:0] hi;
  logic [3:0]                     idx;
  logic [ANG_OUT_BITS-1:0]        mag;
  logic [MASK_BITS-1:0]           mask;
  logic [BEARING_BITS-1:0]        bear;

  // round half up to 1/16 degree and clamp
  assign zh  = din.z + Z_HALF;
  assign raw = zh[ANG_BITS-1:ROUND_SHIFT];

  always_comb begin
    if (din.zero) begin
      ang_next = '0;
    end else if (raw > RAW_MAX) begin
      ang_next = ANG_OUT_BITS'(ANG_LIMIT);
    end else if (raw < RAW_MIN) begin
      ang_next = ANG_OUT_BITS'(-ANG_LIMIT);
    end else begin
      ang_next = raw[ANG_OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= ang_next;
      det <= din.det;
    end
  end

  // sector bins, rear wraps around the half turn
  always_comb begin
    mask = '0;
    lo   = '0;
    hi   = '0;
    idx  = '0;
    if (ang >= REAR_HI || ang < REAR_LO) begin
      mask[REAR_BIT] = 1'b1;
    end else begin
      for (int k = 0; k < NUM_BINS; k++) begin
        lo  = ANG_OUT_BITS'(BIN_WIDTH * k - REAR_EDGE);
        hi  = ANG_OUT_BITS'(BIN_WIDTH * (k + 1) - REAR_EDGE);
        idx = (k + SECTOR_BASE >= NUM_SENSORS) ? 4'(k + SECTOR_BASE - NUM_SENSORS)
                                               : 4'(k + SECTOR_BASE);
        if (ang >= lo && ang < hi) begin
          mask[idx] = 1'b1;
        end
      end
    end
  end

  // negative angles drop to whole degrees before wrapping
  assign mag = -ang;

  always_comb begin
    if (ang[ANG_OUT_BITS-1]) begin
      bear = BEARING_BITS'(FULL_TURN) - BEARING_BITS'({mag[ANG_OUT_BITS-1:4], 4'b0000});
    end else begin
      bear = BEARING_BITS'(ang);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.detected    <= det;
      dout.bearing     <= det ? bear : '0;
      dout.sector_mask <= det ? mask : '0;
    end
  end

endmodule
